### design/fdf_pkg.sv
// Shared types and constants for the frame duplicate filter.
package fdf_pkg;

  localparam logic [31:0] TTL_RESET = 32'd1000;
  localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;

  // configuration register indexes (byte address >> 2)
  localparam logic REG_TTL = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } fdf_state_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [15:0] sequence_req;
    logic [15:0] source_id;
    logic [15:0] net_id;
  } fdf_key_t;

  typedef struct packed {
    logic [31:0] stamp;
    fdf_key_t    key;
  } fdf_entry_t;

  localparam int ENTRY_W = $bits(fdf_entry_t);

  // walker status towards the top level
  typedef struct packed {
    logic idle;
    logic valid;
    logic dup;
  } fdf_res_t;

endpackage

### design/frame_duplicate_filter_top.sv
// Frame duplicate filter: each frame's key is checked against a table of
// CACHE_ENTRIES recently seen keys held in a one-port-read RAM, one entry per
// cycle, dropping entries older than ttl_ms on the way; a new frame takes a
// free, expired or oldest slot. The next frame is accepted only after the walk
// through the table, at one RAM read per cycle, has ended (early on a duplicate)
// and its result has moved to the output register. Valid bits clear at reset,
// so the block is ready straight out of reset. ttl_ms sits at byte address 0.
module frame_duplicate_filter_top #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // net_id, source_id, sequence_req, now_ms
  input  logic [7:0]  in_tuser,   // frame_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // is_duplicate, zero padding
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fdf_pkg::*;

  logic [31:0] ttl_r;
  logic        cfg_wr;
  logic        reg_idx;
  fdf_key_t    key;
  fdf_res_t    res;
  logic        start, res_take;
  logic        out_vld_r, out_vld_nxt;
  logic        out_dup_r, out_dup_nxt;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (reg_idx == REG_TTL) ? ttl_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_wr && (reg_idx == REG_TTL)) begin
      ttl_r <= cfg_pwdata;
    end
  end

  assign key.net_id       = in_tdata[15:0];
  assign key.source_id    = in_tdata[31:16];
  assign key.sequence_req = in_tdata[47:32];
  assign key.kind         = in_tuser;

  assign in_tready = res.idle;
  assign start     = in_tvalid && res.idle;

  fdf_walk #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .key_in   (key),
    .now_in   (in_tdata[79:48]),
    .ttl      (ttl_r),
    .res_take (res_take),
    .res      (res)
  );

  // output register parts the result side from the walker
  assign res_take = res.valid && (!out_vld_r || out_tready);

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_dup_nxt = out_dup_r;
    if (out_vld_r && out_tready) out_vld_nxt = 1'b0;
    if (res_take) begin
      out_vld_nxt = 1'b1;
      out_dup_nxt = res.dup;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dup_r <= out_dup_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_dup_r};

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !res_take)
    else $error("result overwrote a waiting transaction");

  a_take_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_vld_r)
    else $error("result lost on the way to the output");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_tready)
    else $error("input accepted while a result is pending in the walker");

endmodule

### design/fdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/fdf_walk.sv
// Table walker: valid bits, entry RAM and the per-frame scan sequencer.
module fdf_walk #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  fdf_pkg::fdf_key_t key_in,
  input  logic [31:0]     now_in,
  input  logic [31:0]     ttl,
  input  logic            res_take,
  output fdf_pkg::fdf_res_t res
);
  import fdf_pkg::*;

  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(CACHE_ENTRIES);

  fdf_state_t state_r, state_nxt;

  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]            issue_r, issue_nxt;
  logic                     ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]            ev_idx_r, ev_idx_nxt;
  logic                     have_free_r, have_free_nxt;
  logic [IW-1:0]            victim_r, victim_nxt;
  logic [31:0]              best_r, best_nxt;
  logic                     dup_r, dup_nxt;
  fdf_key_t                 key_r, key_nxt;
  logic [31:0]              now_r, now_nxt;

  fdf_entry_t rd_entry, wr_entry;
  logic [ENTRY_W-1:0] rdata;
  logic        ram_we;
  logic [31:0] age;
  logic        live, expired, hit;

  fdf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (victim_r),
    .wdata (wr_entry),
    .raddr (issue_r[IW-1:0]),
    .rdata (rdata)
  );

  assign rd_entry       = fdf_entry_t'(rdata);
  assign wr_entry.stamp = now_r;
  assign wr_entry.key   = key_r;

  // modular age against ttl, key compare on the entry read last cycle
  assign age     = now_r - rd_entry.stamp;
  assign live    = valid_r[ev_idx_r];
  assign expired = age > ttl;
  assign hit     = ev_vld_r && live && !expired && (rd_entry.key == key_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_DONE;
        end else if (!ev_vld_r && (issue_r == LAST_CNT)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_nxt     = valid_r;
    issue_nxt     = issue_r;
    ev_vld_nxt    = ev_vld_r;
    ev_idx_nxt    = ev_idx_r;
    have_free_nxt = have_free_r;
    victim_nxt    = victim_r;
    best_nxt      = best_r;
    dup_nxt       = dup_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    ram_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt       = key_in;
          now_nxt       = now_in;
          issue_nxt     = '0;
          ev_vld_nxt    = 1'b0;
          have_free_nxt = 1'b0;
          victim_nxt    = '0;
          best_nxt      = TIME_MAX;
          dup_nxt       = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue_r < LAST_CNT) begin
          issue_nxt  = issue_r + 1'b1;
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = issue_r[IW-1:0];
        end else begin
          ev_vld_nxt = 1'b0;
        end
        if (ev_vld_r) begin
          if (!live) begin
            victim_nxt    = ev_idx_r;
            have_free_nxt = 1'b1;
          end else if (expired) begin
            valid_nxt[ev_idx_r] = 1'b0;
            victim_nxt          = ev_idx_r;
            have_free_nxt       = 1'b1;
          end else if (hit) begin
            dup_nxt    = 1'b1;
            ev_vld_nxt = 1'b0;
          end else if (!have_free_r && (rd_entry.stamp < best_r)) begin
            best_nxt   = rd_entry.stamp;
            victim_nxt = ev_idx_r;
          end
        end
      end
      ST_WRITE: begin
        ram_we              = 1'b1;
        valid_nxt[victim_r] = 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      ev_vld_r <= 1'b0;
      issue_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      ev_vld_r <= ev_vld_nxt;
      issue_r  <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r    <= ev_idx_nxt;
    have_free_r <= have_free_nxt;
    victim_r    <= victim_nxt;
    best_r      <= best_nxt;
    dup_r       <= dup_nxt;
    key_r       <= key_nxt;
    now_r       <= now_nxt;
  end

  assign res.idle  = (state_r == ST_IDLE);
  assign res.valid = (state_r == ST_DONE);
  assign res.dup   = dup_r;

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> valid_r[$past(victim_r)])
    else $error("stored entry not marked valid");

  a_eval_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> !ev_vld_r)
    else $error("entry evaluation outside scan");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r <= LAST_CNT)
    else $error("read index ran past the table");

  a_done_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> $stable(valid_r))
    else $error("valid bits changed while result waits");

endmodule
